>>> rtl/pid_step_anti_windup_defines.svh
// assertion macros shared by the checker
`ifndef PID_STEP_ANTI_WINDUP_DEFINES_SVH
`define PID_STEP_ANTI_WINDUP_DEFINES_SVH

// same-cycle implication, off while reset is high
`define PSAW_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("pid_step_anti_windup check failed");

// next-cycle implication, off while reset is high
`define PSAW_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("pid_step_anti_windup check failed");

// next-cycle implication that also holds across reset
`define PSAW_ASSERT_RST(lbl, pre, post) \
   lbl: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error("pid_step_anti_windup reset check failed");

`endif

>>> rtl/pid_saw_pkg.sv
`default_nettype none

package pid_saw_pkg;

   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int DB_W       = 31;
   localparam int CSR_ADDR_W = 3;
   localparam int REQ_W      = 2 * DATA_W;
   // two data words and two flags, padded to whole bytes
   localparam int RSP_W      = ((2 * DATA_W + 2 + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_W - 2 * DATA_W - 2;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int EPSILON_LSB_DEF = 0;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_KP_GAIN   = 3'd0,
      REG_KI_DT     = 3'd1,
      REG_KD_PER_DT = 3'd2,
      REG_INTEG_MIN = 3'd3,
      REG_INTEG_MAX = 3'd4,
      REG_DRIVE_MIN = 3'd5,
      REG_DRIVE_MAX = 3'd6,
      REG_DEADBAND  = 3'd7
   } csr_reg_type;

endpackage

`default_nettype wire

>>> rtl/pid_step_anti_windup.sv
// PID step with conditional-integration anti-windup. One sample per req_ transfer gives
// one result on rsp_, and a new sample may be transferred every cycle while rsp_ results
// are taken. Stages: input register, saturated error with deadband, error difference,
// three 32x32 gain products, scaling and saturation, then the output register, whose
// combinational loop (integrator add and clamp, output clamp, rollback select) carries
// the integral from one sample to the next. An input skid register lets req_ keep
// moving for one extra transfer while a result waits on rsp_. The user must write
// registers on csr_ only while no sample is in flight; the block does not enforce it.
`default_nettype none

module pid_step_anti_windup
   import pid_saw_pkg::*;
#(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int EPSILON_LSB = EPSILON_LSB_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [REQ_W-1:0]       req_tdata,   // measured, setpoint
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata,   // control_out, error_used, out_clamped,
                                               // integral_held, zero pad
   input  wire                    csr_we,
   input  wire  [CSR_ADDR_W-1:0]  csr_addr,
   input  wire  [DATA_W-1:0]      csr_wdata
);

   localparam logic signed [DATA_W-1:0] MAX_D = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] MIN_D = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W+2:0] EPS_X = (DATA_W+3)'(EPSILON_LSB);

   function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [DATA_W:0] v);
      if (v[DATA_W] != v[DATA_W-1]) begin
         sat_word = v[DATA_W] ? MIN_D : MAX_D;
      end else begin
         sat_word = v[DATA_W-1:0];
      end
   endfunction

   // floor shift of the full product, then saturate
   function automatic logic signed [DATA_W-1:0] scale_prod(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] q;
      logic [PROD_W-DATA_W:0]   hi;
      q  = p >>> FRAC_BITS;
      hi = q[PROD_W-1:DATA_W-1];
      if ((&hi) || !(|hi)) begin
         scale_prod = q[DATA_W-1:0];
      end else begin
         scale_prod = q[PROD_W-1] ? MIN_D : MAX_D;
      end
   endfunction

   function automatic logic signed [DATA_W-1:0] clamp_lim(input logic signed [DATA_W+1:0] v,
                                                          input logic signed [DATA_W-1:0] lo,
                                                          input logic signed [DATA_W-1:0] hi);
      priority if (v < (DATA_W+2)'(lo)) begin
         clamp_lim = lo;
      end else if (v > (DATA_W+2)'(hi)) begin
         clamp_lim = hi;
      end else begin
         clamp_lim = v[DATA_W-1:0];
      end
   endfunction

   // configuration
   logic signed [DATA_W-1:0] kp_ff, ki_ff, kd_ff;
   logic signed [DATA_W-1:0] imin_ff, imax_ff, dmin_ff, dmax_ff;
   logic        [DB_W-1:0]   deadband_ff;

   // control
   logic skid_v_ff, skid_v_in;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_v_ff;
   logic first_ff;
   logic adv, req_xfer, src_v;

   // state
   logic signed [DATA_W-1:0] integ_ff, last_err_ff;

   // payload
   logic        [REQ_W-1:0]  skid_ff, s1_ff, src_data;
   logic signed [DATA_W-1:0] err_s2_ff, err_s3_ff, diff_s3_ff, err_s4_ff, err_s5_ff;
   logic                     dz_s3_ff, dz_s4_ff;
   logic signed [PROD_W-1:0] pp_s4_ff, pi_s4_ff, pd_s4_ff;
   logic signed [DATA_W-1:0] di_s5_ff;
   logic signed [DATA_W:0]   pd_s5_ff;
   logic signed [DATA_W-1:0] ctl_ff, erro_ff;
   logic                     clamped_ff, held_ff;

   // stage logic
   logic signed [DATA_W-1:0] meas_w, setp_w, err_sat, err_in, diff_in;
   logic signed [DATA_W:0]   err_x;
   logic        [DATA_W:0]   err_mag;
   logic signed [DATA_W-1:0] p_in, di_in, d_in;
   logic signed [DATA_W+1:0] isum, raw_a, raw_b, raw_f;
   logic signed [DATA_W-1:0] i_next, sat_a, sat_b, sat_f, integ_in;
   logic signed [DATA_W+2:0] gap_a, gap_mag, ki_mag, di_x;
   logic                     err_pos, err_neg, held_in;

   assign adv        = !rsp_v_ff || rsp_tready;
   assign req_tready = !skid_v_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign src_v      = skid_v_ff || req_xfer;
   assign src_data   = skid_v_ff ? skid_ff : req_tdata;

   always_comb begin
      skid_v_in = skid_v_ff;
      if (adv) begin
         skid_v_in = 1'b0;
      end else if (req_xfer) begin
         skid_v_in = 1'b1;
      end
   end

   // error with deadband
   assign meas_w  = s1_ff[DATA_W-1:0];
   assign setp_w  = s1_ff[2*DATA_W-1:DATA_W];
   assign err_sat = sat_word((DATA_W+1)'(setp_w) - (DATA_W+1)'(meas_w));
   assign err_x   = (DATA_W+1)'(err_sat);
   assign err_mag = err_x[DATA_W] ? -err_x : err_x;
   assign err_in  = (err_mag <= {2'b00, deadband_ff}) ? '0 : err_sat;

   assign diff_in = sat_word((DATA_W+1)'(err_s2_ff) - (DATA_W+1)'(last_err_ff));

   assign p_in  = scale_prod(pp_s4_ff);
   assign di_in = scale_prod(pi_s4_ff);
   assign d_in  = dz_s4_ff ? '0 : scale_prod(pd_s4_ff);

   // integrator and output clamp, with the rollback alternative formed alongside
   assign isum   = (DATA_W+2)'(integ_ff) + (DATA_W+2)'(di_s5_ff);
   assign i_next = clamp_lim(isum, imin_ff, imax_ff);
   assign raw_a  = (DATA_W+2)'(pd_s5_ff) + (DATA_W+2)'(i_next);
   assign raw_b  = (DATA_W+2)'(pd_s5_ff) + (DATA_W+2)'(integ_ff);
   assign sat_a  = clamp_lim(raw_a, dmin_ff, dmax_ff);
   assign sat_b  = clamp_lim(raw_b, dmin_ff, dmax_ff);

   assign gap_a   = (DATA_W+3)'(sat_a) - (DATA_W+3)'(raw_a);
   assign gap_mag = gap_a[DATA_W+2] ? -gap_a : gap_a;
   assign ki_mag  = ki_ff[DATA_W-1] ? -(DATA_W+3)'(ki_ff) : (DATA_W+3)'(ki_ff);
   assign di_x    = (DATA_W+3)'(di_s5_ff);
   assign err_pos = !err_s5_ff[DATA_W-1] && (err_s5_ff != '0);
   assign err_neg = err_s5_ff[DATA_W-1];

   assign held_in = (gap_mag > EPS_X) && (ki_mag > EPS_X)
                    && ((err_pos && (sat_a >= dmax_ff) && (di_x > EPS_X))
                        || (err_neg && (sat_a <= dmin_ff) && (di_x < -EPS_X)));

   assign integ_in = held_in ? integ_ff : i_next;
   assign raw_f    = held_in ? raw_b : raw_a;
   assign sat_f    = held_in ? sat_b : sat_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff       <= '0;
         ki_ff       <= '0;
         kd_ff       <= '0;
         imin_ff     <= MIN_D;
         imax_ff     <= MAX_D;
         dmin_ff     <= MIN_D;
         dmax_ff     <= MAX_D;
         deadband_ff <= '0;
         skid_v_ff   <= 1'b0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
         v5_ff       <= 1'b0;
         rsp_v_ff    <= 1'b0;
         first_ff    <= 1'b1;
         integ_ff    <= '0;
         last_err_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_reg_type'(csr_addr))
               REG_KP_GAIN:   kp_ff       <= csr_wdata;
               REG_KI_DT:     ki_ff       <= csr_wdata;
               REG_KD_PER_DT: kd_ff       <= csr_wdata;
               REG_INTEG_MIN: imin_ff     <= csr_wdata;
               REG_INTEG_MAX: imax_ff     <= csr_wdata;
               REG_DRIVE_MIN: dmin_ff     <= csr_wdata;
               REG_DRIVE_MAX: dmax_ff     <= csr_wdata;
               REG_DEADBAND:  deadband_ff <= csr_wdata[DB_W-1:0];
               default:       ;
            endcase
         end
         skid_v_ff <= skid_v_in;
         if (adv) begin
            v1_ff    <= src_v;
            v2_ff    <= v1_ff;
            v3_ff    <= v2_ff;
            v4_ff    <= v3_ff;
            v5_ff    <= v4_ff;
            rsp_v_ff <= v5_ff;
            if (v2_ff) begin
               last_err_ff <= err_s2_ff;
               first_ff    <= 1'b0;
            end
            if (v5_ff) begin
               integ_ff <= integ_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!adv && req_xfer) begin
         skid_ff <= req_tdata;
      end
      if (adv) begin
         s1_ff      <= src_data;
         err_s2_ff  <= err_in;
         err_s3_ff  <= err_s2_ff;
         diff_s3_ff <= diff_in;
         dz_s3_ff   <= first_ff;
         err_s4_ff  <= err_s3_ff;
         dz_s4_ff   <= dz_s3_ff;
         pp_s4_ff   <= PROD_W'(kp_ff) * PROD_W'(err_s3_ff);
         pi_s4_ff   <= PROD_W'(ki_ff) * PROD_W'(err_s3_ff);
         pd_s4_ff   <= PROD_W'(kd_ff) * PROD_W'(diff_s3_ff);
         err_s5_ff  <= err_s4_ff;
         di_s5_ff   <= di_in;
         pd_s5_ff   <= (DATA_W+1)'(p_in) + (DATA_W+1)'(d_in);
         ctl_ff     <= sat_f;
         erro_ff    <= err_s5_ff;
         clamped_ff <= ((DATA_W+2)'(sat_f) != raw_f);
         held_ff    <= held_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, held_ff, clamped_ff, erro_ff, ctl_ff};

endmodule

`default_nettype wire

>>> rtl/pid_saw_chk.sv
`default_nettype none
`include "pid_step_anti_windup_defines.svh"

module pid_saw_chk
   import pid_saw_pkg::*;
(
   input wire              clock,
   input wire              reset,
   input wire              req_tready,
   input wire              rsp_tvalid,
   input wire              rsp_tready,
   input wire [RSP_W-1:0]  rsp_tdata
);

   // pipeline empties on reset
   `PSAW_ASSERT_RST(a_reset_empty, reset, !rsp_tvalid)

   // a stalled result holds
   `PSAW_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // the skid entry drains whenever the output side moves
   `PSAW_ASSERT_NEXT(a_skid_drain, !req_tready && !(rsp_tvalid && !rsp_tready), req_tready)

   // rollback only happens with a nonzero error
   `PSAW_ASSERT_NOW(a_held_err, rsp_tvalid && rsp_tdata[2*DATA_W+1],
                    rsp_tdata[2*DATA_W-1:DATA_W] != '0)

endmodule

bind pid_step_anti_windup pid_saw_chk u_pid_saw_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
